@@ hw/rtl/cxpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxpc_pkg
// Shared types and constants of the chained XOR packet cipher.
// ----------------------------------------------------------------------------
package cxpc_pkg;

  // Byte position counter width (packet length counted modulo 2^LEN_W).
  localparam int LEN_W = 16;
  // Width of the key advance sum, wide enough for the low key word and length.
  localparam int SUM_W = (LEN_W + 1 > 32) ? (LEN_W + 1) : 32;

  localparam int KEY_W      = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_KEY = 2'd1;

  localparam logic [KEY_W-1:0] INITIAL_KEY_RST = 64'h8754_6CA1_0000_3594;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic             direction;
    logic [KEY_W-1:0] initial_key;
  } cfg_t;

endpackage : cxpc_pkg
`default_nettype wire

@@ hw/rtl/cxpc_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxpc_cfg_regs
// Configuration registers: direction and initial key.
// ----------------------------------------------------------------------------
module cxpc_cfg_regs
  import cxpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  logic             direction_r;
  logic [KEY_W-1:0] ikey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCRYPT;
      ikey_r      <= INITIAL_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DIRECTION:   direction_r <= cfg_wdata[0];
        REG_INITIAL_KEY: ikey_r      <= cfg_wdata[KEY_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg = '{direction: direction_r, initial_key: ikey_r};

endmodule : cxpc_cfg_regs
`default_nettype wire

@@ hw/rtl/cxpc_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cxpc_core
// Per-byte cipher datapath with key, chain and position state.
// ----------------------------------------------------------------------------
module cxpc_core
  import cxpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     res
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             loaded_r, loaded_nxt;
  logic [7:0]       chain_r, chain_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;

  logic [7:0]       kbyte;
  logic [7:0]       obyte;
  logic [KEY_W-1:0] key_shift;
  logic [SUM_W-1:0] len_ext;
  logic [SUM_W-1:0] low_sum;

  assign key_shift = key_r >> {pos_r[2:0], 3'b000};
  assign kbyte     = key_shift[7:0];
  assign obyte     = loaded_r ? (item.data_byte ^ kbyte ^ chain_r) : item.data_byte;

  // Packet length is position + 1, a full 2^LEN_W length included.
  assign len_ext = SUM_W'(pos_r) + SUM_W'(1);
  assign low_sum = SUM_W'(key_r[31:0]) + len_ext;

  always_comb begin
    key_nxt    = key_r;
    loaded_nxt = loaded_r;
    chain_nxt  = chain_r;
    pos_nxt    = pos_r + LEN_W'(1);
    if (item.packet_end) begin
      pos_nxt   = '0;
      chain_nxt = '0;
      if (loaded_r) begin
        key_nxt = {key_r[KEY_W-1:32], low_sum[31:0]};
      end else begin
        key_nxt    = cfg.initial_key;
        loaded_nxt = 1'b1;
      end
    end else if (loaded_r) begin
      chain_nxt = (cfg.direction == DIR_DECRYPT) ? item.data_byte : obyte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      chain_r  <= '0;
      pos_r    <= '0;
    end else if (step) begin
      loaded_r <= loaded_nxt;
      chain_r  <= chain_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_r <= key_nxt;
    end
  end

  assign res = '{out_byte: obyte, out_last: item.packet_end};

  a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r |=> loaded_r)
    else $error("key loaded flag dropped");

  a_unkeyed_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !loaded_r |-> chain_r == 8'd0)
    else $error("chain nonzero before key load");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.packet_end |=> pos_r == '0 && chain_r == 8'd0)
    else $error("position or chain not cleared at packet end");

endmodule : cxpc_core
`default_nettype wire

@@ hw/rtl/chained_xor_packet_cipher_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chained_xor_packet_cipher_top
// Chained XOR packet cipher with rolling key, one byte per item.
// ----------------------------------------------------------------------------
// Each item carries one packet body byte and a last-byte flag, and yields one
// result byte. Throughput is one item per clock unless a full result register
// is held by out_ready; each item passes through an input register, then the
// cipher step into the result register. The rate is set by the chain
// feedback: the XOR of byte, key byte and previous ciphertext byte, and the
// 32-bit key advance at packet end. The first packet after reset passes
// through unchanged and loads the key from the initial-key register.
// Configuration writes are expected only while no items are in flight.
// ----------------------------------------------------------------------------
module chained_xor_packet_cipher_top
  import cxpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_vld_r;
  out_item_t out_item_r;
  logic      out_vld_r;
  out_item_t res;
  logic      advance;

  cxpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cxpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Advance when an input item is held and the result register is empty or being drained.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result register not filled after advance");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_item_r))
    else $error("stalled input item lost or changed");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_item_r.out_last == $past(in_item_r.packet_end))
    else $error("last flag not carried to result");

endmodule : chained_xor_packet_cipher_top
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the chained XOR packet cipher.
// ----------------------------------------------------------------------------
// Packets of body bytes are sent over the input channel. A cycle-free
// predictor mirrors the cipher: the unkeyed first packet, the key load, the
// chaining in both directions and the key advance at packet end. Every result
// is compared with the oldest predicted byte. Both channels idle at random,
// and the direction changes between and inside packets.
// ----------------------------------------------------------------------------
module tb_top;
  import cxpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state
  logic             dir_mirror;
  logic [KEY_W-1:0] init_key_mirror;
  logic [KEY_W-1:0] roll_key;
  logic             key_ready;
  logic [7:0]       chain_q;
  logic [LEN_W-1:0] byte_pos;

  out_item_t pending_out[$];
  int        error_count;
  int        stall_cycles;
  bit        idle_en;

  chained_xor_packet_cipher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the result byte of one accepted item and advance the state.
  function automatic out_item_t next_cipher_out(input in_item_t it);
    out_item_t  r;
    logic [7:0] kb;
    r.out_last = it.packet_end;
    if (!key_ready) begin
      r.out_byte = it.data_byte;
      if (it.packet_end) begin
        roll_key  = init_key_mirror;
        key_ready = 1'b1;
        byte_pos  = '0;
        chain_q   = '0;
      end else begin
        byte_pos = byte_pos + 1'b1;
      end
    end else begin
      kb         = roll_key[8*byte_pos[2:0] +: 8];
      r.out_byte = it.data_byte ^ kb ^ chain_q;
      chain_q    = (dir_mirror == DIR_DECRYPT) ? it.data_byte : r.out_byte;
      if (it.packet_end) begin
        // a full 2^LEN_W length is added in full
        roll_key[31:0] = roll_key[31:0] + 32'(byte_pos) + 32'd1;
        byte_pos       = '0;
        chain_q        = '0;
      end else begin
        byte_pos = byte_pos + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] dir_word(input logic d);
    logic [CFG_DATA_W-1:0] w;
    w    = {$urandom, $urandom};
    w[0] = d;
    return w;
  endfunction

  // Enter and leave at a falling edge.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = a;
    cfg_wdata = v;
    @(posedge clk);
    if (a == REG_DIRECTION) begin
      dir_mirror = v[0];
    end else if (a == REG_INITIAL_KEY) begin
      init_key_mirror = v;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Send one item; valid stays high on return so back-to-back items flow.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte  = b;
    it.packet_end = last;
    if (idle_en && $urandom_range(0, 11) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    pending_out.push_back(next_cipher_out(it));
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted byte has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // First packet passes through; the key is chosen in the middle of it.
  task automatic test_unkeyed_packet();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    drain();
    case ($urandom_range(0, 3))
      0: ;
      1: write_reg(REG_INITIAL_KEY, '1);
      2: write_reg(REG_INITIAL_KEY, '0);
      default: write_reg(REG_INITIAL_KEY, {$urandom, 24'hFFFFFF, 8'($urandom)});
    endcase
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Key writes after the load and writes to unused indexes change nothing.
  task automatic test_ignored_writes();
    drain();
    write_reg(REG_INITIAL_KEY, {$urandom, $urandom});
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    send_packet('{8'h3C, 8'hC3, 8'h81});
  endtask

  task automatic test_directed_keyed();
    drain();
    write_reg(REG_DIRECTION, dir_word(DIR_ENCRYPT));
    send_packet('{8'hFF});
    send_packet('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hA5});
    drain();
    write_reg(REG_DIRECTION, dir_word(DIR_DECRYPT));
    send_packet('{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80});
    // flip direction inside a packet; the chain carries over
    send_byte(8'h12, 1'b0);
    send_byte(8'hED, 1'b0);
    drain();
    write_reg(REG_DIRECTION, dir_word(DIR_ENCRYPT));
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_packets(input int n_items, input bit with_idle);
    int   sent;
    int   len;
    int   split;
    logic flip_dir;
    sent = 0;
    while (sent < n_items) begin
      idle_en = with_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_reg(REG_DIRECTION, dir_word(1'($urandom_range(0, 1))));
      end else if ($urandom_range(0, 29) == 0) begin
        drain();
      end
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      split = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == split) begin
          drain();
          flip_dir = ~dir_mirror;
          write_reg(REG_DIRECTION, dir_word(flip_dir));
        end
        send_byte(8'($urandom), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    idle_en         = 1'b1;
    error_count     = 0;
    dir_mirror      = DIR_ENCRYPT;
    init_key_mirror = INITIAL_KEY_RST;
    roll_key        = '0;
    key_ready       = 1'b0;
    chain_q         = '0;
    byte_pos        = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_unkeyed_packet();
    test_ignored_writes();
    test_directed_keyed();
    test_random_packets(1000, 1'b1);
    test_random_packets(700, 1'b1);
    test_random_packets(300, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 11) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected item: out_byte %02h out_last %0b",
                 $time, out_data.out_byte, out_data.out_last);
        error_count++;
      end else begin
        exp_item = pending_out.pop_front();
        if (out_data.out_byte !== exp_item.out_byte) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, exp_item.out_byte, out_data.out_byte);
          error_count++;
        end
        if (out_data.out_last !== exp_item.out_last) begin
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, exp_item.out_last, out_data.out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

@@ chained_xor_packet_cipher_top.f @@
hw/rtl/cxpc_pkg.sv
hw/rtl/cxpc_cfg_regs.sv
hw/rtl/cxpc_core.sv
hw/rtl/chained_xor_packet_cipher_top.sv
sim/tb_top.sv
